@@ rtl/core/gpns_pkg.sv @@
// gpns_pkg: shared types and constants of the grid probe nearest search core
// coordinate formats, register indexes, command codes, beat layouts
// no dependencies
package gpns_pkg;

  localparam int unsigned CoordW   = 24;  // signed Q15.8
  localparam int unsigned StepW    = 23;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned SqW      = 2 * CoordW + 1;
  localparam int unsigned DistW    = SqW + 1;
  localparam int unsigned IdxOutW  = 10;
  localparam int unsigned CntOutW  = 11;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic CmdPlace = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_START_Z   = 3'd2,
    REG_END_X     = 3'd3,
    REG_END_Y     = 3'd4,
    REG_END_Z     = 3'd5,
    REG_GRID_STEP = 3'd6
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t             start_x;
    coord_t             start_y;
    coord_t             start_z;
    coord_t             end_x;
    coord_t             end_y;
    coord_t             end_z;
    logic [StepW-1:0]   step;
  } cfg_t;

  typedef struct packed {
    logic               found;
    logic [IdxOutW-1:0] idx;
    point_t             pt;
  } res_t;

  typedef struct packed {
    logic done;
    logic overflow;
  } gen_status_t;

endpackage

@@ rtl/core/grid_probe_nearest_search_core.sv @@
// grid_probe_nearest_search_core: top level, config registers, command sequencer
// and output register; uses gpns_pkg, gpns_point_mem, gpns_grid_gen, gpns_dist_unit
//
// Keeps up to MAX_POINTS points (signed Q15.8) in a single-port-read point memory.
// A place beat (tuser 0) refills the table with the configured grid, writing one
// point per cycle. A query beat (tuser 1) streams every stored point through the
// one read port of that memory into a four-stage squared-distance pipeline and a
// running minimum. One beat is worked on at a time; the finished result sits in an
// output register, and the next beat is taken while it waits.
// The stored point count bounds every read, so no clearing pass runs after reset.
// Configuration writes are meant for idle periods only.
module grid_probe_nearest_search_core #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gpns_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gpns_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // query_x, query_y, query_z
  input  logic [gpns_pkg::InDataW-1:0]     s_axis_tdata,
  // cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found, nearest_index, nearest_x, nearest_y, nearest_z, point_count,
  // overflowed, one pad bit
  output logic [gpns_pkg::OutDataW-1:0]    m_axis_tdata
);
  import gpns_pkg::*;

  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PLACE  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg_q;
  logic [CntW-1:0] count_q;
  logic            ovf_q;
  res_t            res_q;
  logic            out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic        in_acc, out_free;
  logic        gen_start, dist_start;
  point_t      query;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  point_t           wr_pt;
  gen_status_t      gen_status;
  logic [CntW-1:0]  gen_count;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  point_t           rd_pt;
  logic             dist_done, dist_found;
  logic [AddrW-1:0] dist_idx;
  point_t           dist_pt;

  logic [AddrW+IdxOutW-1:0] idx_ext;
  logic [CntW+CntOutW-1:0]  cnt_ext;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_vld_q | m_axis_tready;
  assign query    = '{x: s_axis_tdata[23:0], y: s_axis_tdata[47:24],
                      z: s_axis_tdata[71:48]};

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x <= '0;
      cfg_q.start_y <= '0;
      cfg_q.start_z <= '0;
      cfg_q.end_x   <= CoordW'(2560);
      cfg_q.end_y   <= CoordW'(2560);
      cfg_q.end_z   <= CoordW'(2560);
      cfg_q.step    <= StepW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_X:   cfg_q.start_x <= cfg_wdata_i;
        REG_START_Y:   cfg_q.start_y <= cfg_wdata_i;
        REG_START_Z:   cfg_q.start_z <= cfg_wdata_i;
        REG_END_X:     cfg_q.end_x   <= cfg_wdata_i;
        REG_END_Y:     cfg_q.end_y   <= cfg_wdata_i;
        REG_END_Z:     cfg_q.end_z   <= cfg_wdata_i;
        REG_GRID_STEP: cfg_q.step    <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    gen_start  = 1'b0;
    dist_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == CmdPlace) begin
            gen_start = 1'b1;
            state_d   = ST_PLACE;
          end else begin
            dist_start = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_PLACE: begin
        if (gen_status.done) state_d = ST_RESULT;
      end
      ST_SCAN: begin
        if (dist_done) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  assign idx_ext = {{IdxOutW{1'b0}}, dist_idx};
  assign cnt_ext = {{CntOutW{1'b0}}, count_q};

  assign out_data_d = {1'b0, ovf_q, cnt_ext[CntOutW-1:0], res_q.pt.z, res_q.pt.y,
                       res_q.pt.x, res_q.idx, res_q.found};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PLACE && gen_status.done) begin
        count_q <= gen_count;
        ovf_q   <= gen_status.overflow;
      end
      if (state_q == ST_RESULT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PLACE && gen_status.done) begin
      res_q <= '0;
    end else if (state_q == ST_SCAN && dist_done) begin
      res_q.found <= dist_found;
      // an empty table reports zeros
      res_q.idx   <= dist_found ? idx_ext[IdxOutW-1:0] : '0;
      res_q.pt    <= dist_found ? dist_pt : '0;
    end
    if (state_q == ST_RESULT && out_free) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  gpns_point_mem #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_pt_i   (wr_pt),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_pt_o   (rd_pt)
  );

  gpns_grid_gen #(
    .MaxPoints (MAX_POINTS),
    .AddrW     (AddrW),
    .CntW      (CntW)
  ) u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (gen_start),
    .cfg_i     (cfg_q),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_pt_o   (wr_pt),
    .status_o  (gen_status),
    .count_o   (gen_count)
  );

  gpns_dist_unit #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dist_start),
    .count_i   (count_q),
    .query_i   (query),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_pt_i   (rd_pt),
    .done_o    (dist_done),
    .found_o   (dist_found),
    .idx_o     (dist_idx),
    .pt_o      (dist_pt)
  );

endmodule

@@ rtl/core/gpns_point_mem.sv @@
// gpns_point_mem: point table, one write port and one registered read port
// depends on gpns_pkg for the point layout
module gpns_point_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  gpns_pkg::point_t  wr_pt_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output gpns_pkg::point_t  rd_pt_o
);
  import gpns_pkg::*;

  point_t mem_q [Depth];
  point_t rd_pt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_pt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_pt_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_pt_o = rd_pt_q;

endmodule

@@ rtl/core/gpns_grid_gen.sv @@
// gpns_grid_gen: walks the grid x outer, z inner, one table write per cycle
// stops at the grid end, at a full table or on an empty grid; depends on gpns_pkg
module gpns_grid_gen #(
  parameter int unsigned MaxPoints = 1024,
  parameter int unsigned AddrW     = 10,
  parameter int unsigned CntW      = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  gpns_pkg::cfg_t         cfg_i,
  output logic                   wr_en_o,
  output logic [AddrW-1:0]       wr_addr_o,
  output gpns_pkg::point_t       wr_pt_o,
  output gpns_pkg::gen_status_t  status_o,
  output logic [CntW-1:0]        count_o
);
  import gpns_pkg::*;

  localparam int unsigned SumW = CoordW + 2;

  logic            run_q;
  logic            empty_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  coord_t          cx_q, cy_q, cz_q;
  coord_t          cx_d, cy_d, cz_d;

  logic signed [SumW-1:0] step_s;
  logic signed [SumW-1:0] nx_s, ny_s, nz_s;
  logic                   wrap_x, wrap_y, wrap_z;
  logic                   grid_last, full, fin;
  logic                   empty_d;

  assign step_s = $signed({{(SumW-StepW){1'b0}}, cfg_i.step});
  assign nx_s   = $signed({{2{cx_q[CoordW-1]}}, cx_q}) + step_s;
  assign ny_s   = $signed({{2{cy_q[CoordW-1]}}, cy_q}) + step_s;
  assign nz_s   = $signed({{2{cz_q[CoordW-1]}}, cz_q}) + step_s;

  // an axis wraps once the next coordinate passes the inclusive end
  assign wrap_x = nx_s > $signed({{2{cfg_i.end_x[CoordW-1]}}, cfg_i.end_x});
  assign wrap_y = ny_s > $signed({{2{cfg_i.end_y[CoordW-1]}}, cfg_i.end_y});
  assign wrap_z = nz_s > $signed({{2{cfg_i.end_z[CoordW-1]}}, cfg_i.end_z});

  assign grid_last = wrap_x & wrap_y & wrap_z;
  assign full      = (cnt_q == CntW'(MaxPoints - 1));
  assign fin       = empty_q | grid_last | full;

  assign empty_d = ($signed(cfg_i.end_x) < $signed(cfg_i.start_x))
                 | ($signed(cfg_i.end_y) < $signed(cfg_i.start_y))
                 | ($signed(cfg_i.end_z) < $signed(cfg_i.start_z));

  assign wr_en_o   = run_q & ~empty_q;
  assign wr_addr_o = cnt_q[AddrW-1:0];
  assign wr_pt_o   = '{x: cx_q, y: cy_q, z: cz_q};

  assign status_o.done     = run_q & fin;
  assign status_o.overflow = ~empty_q & ~grid_last;
  assign count_o           = empty_q ? '0 : cnt_q + CntW'(1);

  always_comb begin
    cnt_d = cnt_q + CntW'(1);
    cz_d  = wrap_z ? cfg_i.start_z : nz_s[CoordW-1:0];
    cy_d  = cy_q;
    cx_d  = cx_q;
    if (wrap_z) begin
      cy_d = wrap_y ? cfg_i.start_y : ny_s[CoordW-1:0];
      if (wrap_y) begin
        cx_d = nx_s[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      if (fin) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      empty_q <= empty_d;
      cx_q    <= cfg_i.start_x;
      cy_q    <= cfg_i.start_y;
      cz_q    <= cfg_i.start_z;
    end else if (run_q && !fin) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end

endmodule

@@ rtl/core/gpns_dist_unit.sv @@
// gpns_dist_unit: scans the point table through the memory read port,
// pipelined squared distance and running minimum; depends on gpns_pkg
module gpns_dist_unit #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned CntW  = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CntW-1:0]   count_i,
  input  gpns_pkg::point_t  query_i,
  output logic              rd_en_o,
  output logic [AddrW-1:0]  rd_addr_o,
  input  gpns_pkg::point_t  rd_pt_i,
  output logic              done_o,
  output logic              found_o,
  output logic [AddrW-1:0]  idx_o,
  output gpns_pkg::point_t  pt_o
);
  import gpns_pkg::*;

  logic            busy_q;
  logic [CntW-1:0] issue_q, lim_q;
  point_t          qry_q;
  logic            issue;

  // stage 0: read data back from memory
  logic             v0_q;
  logic [AddrW-1:0] i0_q;
  // stage 1: per-axis differences
  logic             v1_q;
  logic [AddrW-1:0] i1_q;
  point_t           p1_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  // stage 2: squares
  logic             v2_q;
  logic [AddrW-1:0] i2_q;
  point_t           p2_q;
  logic [SqW-1:0]   sx_q, sy_q, sz_q;
  // stage 3: sum
  logic             v3_q;
  logic [AddrW-1:0] i3_q;
  point_t           p3_q;
  logic [DistW-1:0] sum_q;
  // running best
  logic             found_q;
  logic [DistW-1:0] best_q;
  logic [AddrW-1:0] best_idx_q;
  point_t           best_pt_q;

  logic signed [DiffW-1:0]   dx_d, dy_d, dz_d;
  logic signed [2*DiffW-1:0] px, py, pz;
  logic [DistW-1:0]          sum_d;
  logic                      win;

  assign issue     = busy_q & (issue_q != lim_q);
  assign rd_en_o   = issue;
  assign rd_addr_o = issue_q[AddrW-1:0];
  assign done_o    = busy_q & ~issue & ~v0_q & ~v1_q & ~v2_q & ~v3_q;

  assign dx_d = $signed({rd_pt_i.x[CoordW-1], rd_pt_i.x})
              - $signed({qry_q.x[CoordW-1], qry_q.x});
  assign dy_d = $signed({rd_pt_i.y[CoordW-1], rd_pt_i.y})
              - $signed({qry_q.y[CoordW-1], qry_q.y});
  assign dz_d = $signed({rd_pt_i.z[CoordW-1], rd_pt_i.z})
              - $signed({qry_q.z[CoordW-1], qry_q.z});

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  assign sum_d = {1'b0, sx_q} + {1'b0, sy_q} + {1'b0, sz_q};

  // strict compare keeps the lowest index on a tie
  assign win = v3_q & (~found_q | (sum_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= '0;
      lim_q   <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v0_q <= issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (start_i) begin
        busy_q  <= 1'b1;
        issue_q <= '0;
        lim_q   <= count_i;
        found_q <= 1'b0;
      end else begin
        if (issue) begin
          issue_q <= issue_q + CntW'(1);
        end
        if (done_o) begin
          busy_q <= 1'b0;
        end
        if (win) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qry_q <= query_i;
    end
    i0_q <= issue_q[AddrW-1:0];
    i1_q <= i0_q;
    p1_q <= rd_pt_i;
    dx_q <= dx_d;
    dy_q <= dy_d;
    dz_q <= dz_d;
    i2_q <= i1_q;
    p2_q <= p1_q;
    sx_q <= px[SqW-1:0];
    sy_q <= py[SqW-1:0];
    sz_q <= pz[SqW-1:0];
    i3_q <= i2_q;
    p3_q <= p2_q;
    sum_q <= sum_d;
    if (win) begin
      best_q     <= sum_q;
      best_idx_q <= i3_q;
      best_pt_q  <= p3_q;
    end
  end

  assign found_o = found_q;
  assign idx_o   = best_idx_q;
  assign pt_o    = best_pt_q;

endmodule

@@ rtl/core/gpns_checker.sv @@
// gpns_checker: port-level assertions for the grid probe nearest search core
// bound to grid_probe_nearest_search_core; depends on gpns_pkg
module gpns_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gpns_pkg::OutDataW-1:0] m_axis_tdata
);
  import gpns_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one command in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in work");

  // a result only shows up after a command was in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result beat without a command in work");

endmodule

bind grid_probe_nearest_search_core gpns_checker u_gpns_checker (.*);

@@ sim/testbench.sv @@
// testbench: checks grid_probe_nearest_search_core against a behavioral predictor
// of grid placement and nearest-point search, beat by beat, with random stalls
// depends on gpns_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;
  import gpns_pkg::*;

  localparam int unsigned TableDepth = 1024;
  // budget for about 600 beats of the worst-case length, taken several times over
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned BeatTarget = 580;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
  localparam longint CoordMin = -8388608;
  localparam longint CoordMax = 8388607;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic               found;
    logic [IdxOutW-1:0] idx;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [CntOutW-1:0] count;
    logic               ovf;
  } search_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  grid_probe_nearest_search_core #(
    .MAX_POINTS(TableDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  class nearest_scoreboard;
    coord_t           px[TableDepth];
    coord_t           py[TableDepth];
    coord_t           pz[TableDepth];
    int unsigned      stored;
    bit               overflow;
    coord_t           start_x, start_y, start_z;
    coord_t           end_x, end_y, end_z;
    logic [StepW-1:0] pitch;
    search_result_t   search_results_q[$];
    int unsigned      errors;

    function new();
      stored   = 0;
      overflow = 1'b0;
      start_x  = 0;
      start_y  = 0;
      start_z  = 0;
      end_x    = 2560;
      end_y    = 2560;
      end_z    = 2560;
      pitch    = 256;
      errors   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_START_X:   start_x = data;
        REG_START_Y:   start_y = data;
        REG_START_Z:   start_z = data;
        REG_END_X:     end_x = data;
        REG_END_Y:     end_y = data;
        REG_END_Z:     end_z = data;
        REG_GRID_STEP: pitch = data[StepW-1:0];
        default: ;
      endcase
    endfunction

    function u64_t axis_points(coord_t lo, coord_t hi);
      if (hi < lo) return 0;
      // zero pitch repeats the start value forever
      if (pitch == 0) return u64_t'(1) << 30;
      return u64_t'(longint'(hi) - longint'(lo)) / u64_t'(pitch) + 1;
    endfunction

    function u64_t capped_product(u64_t a, u64_t b);
      u64_t cap;
      u64_t p;
      cap = TableDepth + 1;
      if (a > cap) a = cap;
      if (b > cap) b = cap;
      p = a * b;
      return (p > cap) ? cap : p;
    endfunction

    function void place_grid();
      u64_t   nx, ny, nz, total, iy, iz;
      longint cx, cy, cz;
      nx = axis_points(start_x, end_x);
      ny = axis_points(start_y, end_y);
      nz = axis_points(start_z, end_z);
      total = capped_product(capped_product(nx, ny), nz);
      overflow = (total > TableDepth);
      stored = overflow ? TableDepth : int'(total);
      iy = 0;
      iz = 0;
      cx = start_x;
      cy = start_y;
      cz = start_z;
      for (int unsigned i = 0; i < stored; i++) begin
        px[i] = coord_t'(cx);
        py[i] = coord_t'(cy);
        pz[i] = coord_t'(cz);
        iz++;
        cz += longint'(pitch);
        if (iz >= nz) begin
          iz = 0;
          cz = start_z;
          iy++;
          cy += longint'(pitch);
          if (iy >= ny) begin
            iy = 0;
            cy = start_y;
            cx += longint'(pitch);
          end
        end
      end
    endfunction

    function u64_t sq_diff(coord_t a, coord_t b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return u64_t'(d) * u64_t'(d);
    endfunction

    function void note_beat(logic cmd, coord_t qx, coord_t qy, coord_t qz);
      search_result_t r;
      u64_t           best, d;
      r = '0;
      best = 0;
      if (cmd == CmdPlace) begin
        place_grid();
      end else begin
        // strict less-than keeps the lowest index on a tie
        for (int unsigned i = 0; i < stored; i++) begin
          d = sq_diff(px[i], qx) + sq_diff(py[i], qy) + sq_diff(pz[i], qz);
          if (!r.found || d < best) begin
            r.found = 1'b1;
            best = d;
            r.idx = IdxOutW'(i);
          end
        end
        if (r.found) begin
          r.x = px[r.idx];
          r.y = py[r.idx];
          r.z = pz[r.idx];
        end
      end
      r.count = CntOutW'(stored);
      r.ovf = overflow;
      search_results_q.insert(search_results_q.size(), r);
    endfunction

    function void match_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [OutDataW-1:0] data);
      search_result_t want, got;
      got.found = data[0];
      got.idx   = data[10:1];
      got.x     = data[34:11];
      got.y     = data[58:35];
      got.z     = data[82:59];
      got.count = data[93:83];
      got.ovf   = data[94];
      if (search_results_q.size() == 0) begin
        $error("result beat with no search pending");
        errors++;
        return;
      end
      want = search_results_q.pop_front();
      match_field("found", want.found, got.found);
      match_field("nearest_index", want.idx, got.idx);
      match_field("nearest_x", want.x, got.x);
      match_field("nearest_y", want.y, got.y);
      match_field("nearest_z", want.z, got.z);
      match_field("point_count", want.count, got.count);
      match_field("overflowed", want.ovf, got.ovf);
    endfunction

    function int unsigned pending();
      return search_results_q.size();
    endfunction
  endclass

  nearest_scoreboard sb;

  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned sender_idle_pct = 25;
  int unsigned receiver_idle_pct = 48;
  bit          hold_arm = 1'b0;
  int unsigned hold_left = 0;

  // current grid, used to aim queries at it
  longint grid_lo[3];
  longint grid_cnt[3];
  longint grid_pitch;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    if (hold_arm) begin
      hold_left = HoldCycles;
      hold_arm = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic coord_t clamp_coord(longint v);
    if (v < CoordMin) v = CoordMin;
    if (v > CoordMax) v = CoordMax;
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  task automatic send_beat(logic cmd, coord_t qx, coord_t qy, coord_t qz);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {qz, qy, qx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(cmd, qx, qy, qz);
    beats_sent++;
    if (beats_sent == 200) begin
      sender_idle_pct = 48;
      receiver_idle_pct = 25;
    end else if (beats_sent == 400) begin
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
  endtask

  task automatic set_grid(longint sx, longint sy, longint sz, longint ex, longint ey,
                          longint ez, logic [CfgDataW-1:0] pitch_word);
    write_reg(REG_START_X, CfgDataW'(sx));
    write_reg(REG_START_Y, CfgDataW'(sy));
    write_reg(REG_START_Z, CfgDataW'(sz));
    write_reg(REG_END_X, CfgDataW'(ex));
    write_reg(REG_END_Y, CfgDataW'(ey));
    write_reg(REG_END_Z, CfgDataW'(ez));
    write_reg(REG_GRID_STEP, pitch_word);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic place_beat();
    send_beat(CmdPlace, any_coord(), any_coord(), any_coord());
  endtask

  // wait until every result beat has come back, plus a margin
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random_beat();
    longint      q[3];
    int unsigned kind;
    kind = $urandom_range(9);
    for (int a = 0; a < 3; a++) begin
      if (kind <= 4) begin
        q[a] = grid_lo[a] - grid_pitch
             + $urandom_range(int'((grid_cnt[a] + 1) * grid_pitch));
      end else if (kind <= 7) begin
        q[a] = grid_lo[a] + $urandom_range(int'(grid_cnt[a] - 1)) * grid_pitch;
      end else begin
        q[a] = any_coord();
      end
    end
    // halfway between two z neighbors: a tie when the pitch is even
    if (kind == 7) q[2] = q[2] + grid_pitch / 2;
    if (kind == 9) place_beat();
    else send_beat(CmdQuery, clamp_coord(q[0]), clamp_coord(q[1]), clamp_coord(q[2]));
  endtask

  task automatic run_phase(bit pressure);
    longint      hi[3];
    longint      span, max_pitch, maxcnt;
    int          ax;
    int unsigned nq;
    bit          big;
    big = ($urandom_range(9) == 0);
    maxcnt = 1;
    for (int a = 0; a < 3; a++) begin
      grid_cnt[a] = big ? $urandom_range(8, 12) : $urandom_range(1, 4);
      if (grid_cnt[a] > maxcnt) maxcnt = grid_cnt[a];
    end
    case ($urandom_range(3))
      0:       grid_pitch = $urandom_range(1, 16);
      1:       grid_pitch = $urandom_range(17, 1024);
      2:       grid_pitch = $urandom_range(1025, 65536);
      default: grid_pitch = $urandom_range(65537, 8388607);
    endcase
    if (maxcnt > 1) begin
      max_pitch = 16777215 / (maxcnt - 1);
      if (grid_pitch > max_pitch) grid_pitch = max_pitch;
    end
    for (int a = 0; a < 3; a++) begin
      span = (grid_cnt[a] - 1) * grid_pitch;
      grid_lo[a] = CoordMin + $urandom_range(int'(CoordMax - span - CoordMin));
      hi[a] = grid_lo[a] + span + $urandom_range(int'(grid_pitch - 1));
      if (hi[a] > CoordMax) hi[a] = CoordMax;
    end
    // now and then one axis ends below its start
    if ($urandom_range(11) == 0) begin
      ax = $urandom_range(2);
      grid_lo[ax] = CoordMin + 1 + $urandom_range(16777214);
      hi[ax] = grid_lo[ax] - 1 - $urandom_range(int'(grid_lo[ax] - CoordMin - 1));
    end
    if ($urandom_range(7) == 0) write_reg(RegSpare, CfgDataW'($urandom()));
    set_grid(grid_lo[0], grid_lo[1], grid_lo[2], hi[0], hi[1], hi[2],
             {1'($urandom_range(1)), StepW'(grid_pitch)});
    if (pressure) hold_arm = 1'b1;
    if ($urandom_range(5) != 0) place_beat();
    nq = big ? 3 : $urandom_range(6, 18);
    repeat (nq) send_random_beat();
    drain();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, then the reset grid of 11 points per axis overflows the table
    send_beat(CmdQuery, CoordMax, CoordMin, 0);
    place_beat();
    send_beat(CmdQuery, 0, 0, 0);
    send_beat(CmdQuery, 0, 0, 128);
    send_beat(CmdQuery, CoordMax, CoordMax, CoordMax);
    send_beat(CmdQuery, CoordMin, CoordMin, CoordMin);
    drain();

    // zero pitch once bit 23 is masked off: table full of the start corner
    set_grid(-300, 5, 77, 1000, 2000, 3000, 24'h800000);
    place_beat();
    send_beat(CmdQuery, any_coord(), any_coord(), any_coord());
    drain();

    // x ends below its start: nothing is stored
    set_grid(100, 0, 0, 99, 512, 512, 256);
    place_beat();
    send_beat(CmdQuery, 100, 0, 0);
    drain();

    // whole coordinate range, three points per axis
    set_grid(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, 24'h7fffff);
    place_beat();
    send_beat(CmdQuery, CoordMax, CoordMax, CoordMax);
    send_beat(CmdQuery, CoordMin, CoordMin, CoordMin);
    drain();

    // single point; a write to an unused index must not disturb anything
    write_reg(RegSpare, 24'hffffff);
    set_grid(1234, -1234, 42, 1234, -1234, 42, 1);
    place_beat();
    send_beat(CmdQuery, any_coord(), any_coord(), any_coord());
    drain();

    // exactly the table depth, then one point over it
    set_grid(0, 0, 0, 0, 31, 31, 1);
    place_beat();
    send_beat(CmdQuery, 0, 31, 31);
    drain();
    set_grid(0, 0, 0, 4, 4, 40, 1);
    place_beat();
    send_beat(CmdQuery, 4, 4, 40);
    drain();

    for (int ph = 0; beats_sent < BeatTarget; ph++) run_phase(ph == 3);

    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/gpns_pkg.sv
rtl/core/gpns_point_mem.sv
rtl/core/gpns_grid_gen.sv
rtl/core/gpns_dist_unit.sv
rtl/core/grid_probe_nearest_search_core.sv
rtl/core/gpns_checker.sv
sim/testbench.sv
